// File: rtl/core/smcoo_pkg.sv
// Shared types and codes for the sparse coordinate-list matrix adder.
package smcoo_pkg;

    localparam int DIM_W   = 17;
    localparam int IDX16_W = 16;
    localparam int VAL_W   = 32;
    localparam int ENTRY_W = 2 * IDX16_W + VAL_W;

    localparam logic [DIM_W-1:0] DIM_RESET = 17'd65536;

    // request commands
    localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
    localparam logic [1:0] CMD_MERGE       = 2'd2;
    localparam logic [1:0] CMD_NONE        = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_ENTRY    = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd3;

    // configuration register indexes (word address)
    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_COLS_A = 2'd1;
    localparam logic [1:0] REG_ROWS_B = 2'd2;
    localparam logic [1:0] REG_COLS_B = 2'd3;

    typedef struct packed {
        logic [1:0]               cmd;
        logic [IDX16_W-1:0]       row;
        logic [IDX16_W-1:0]       col;
        logic signed [VAL_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        logic [IDX16_W-1:0]       out_row;
        logic [IDX16_W-1:0]       out_col;
        logic signed [VAL_W-1:0]  out_value;
        logic [1:0]               status;
        logic                     last;
    } out_item_t;

    typedef struct packed {
        logic [DIM_W-1:0] rows_a;
        logic [DIM_W-1:0] cols_a;
        logic [DIM_W-1:0] rows_b;
        logic [DIM_W-1:0] cols_b;
    } dims_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_MERGE
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic clear;
        logic emit_err;
        logic emit_merge;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] err;
        logic       merge_last;
        logic       out_free;
    } dp_status_t;

endpackage

// File: rtl/core/sparse_matrix_coo_add.sv
// Sequence: a load transaction gives no result. A merge first spends the fetch state reading
// the list heads, then gives one result per unstalled cycle in the merge state, and holds the
// request side until its last result is registered; an error merge gives its one result from
// the fetch state and holds the request side until that result is registered.
// Throughput: one load per cycle while idle, one result per unstalled cycle (merge pointer loop).
// Reset: rst_n clears counts, overflow flag and result valid, sets the dimensions to 65536.
module sparse_matrix_coo_add #(
    parameter int DEPTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // request channel: loads and merge command
    input  logic                 req_valid,
    output logic                 req_stall,
    input  smcoo_pkg::in_item_t  req_item,
    // result channel
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output smcoo_pkg::out_item_t rsp_item,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import smcoo_pkg::*;

    dims_t      dims_reg, dims_next;
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;
    logic       cfg_write;
    logic [DIM_W-1:0] rd_dim;

    // Register writes land on the access cycle; the port never waits.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        dims_next = dims_reg;
        if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_ROWS_A: dims_next.rows_a = pwdata[DIM_W-1:0];
                REG_COLS_A: dims_next.cols_a = pwdata[DIM_W-1:0];
                REG_ROWS_B: dims_next.rows_b = pwdata[DIM_W-1:0];
                REG_COLS_B: dims_next.cols_b = pwdata[DIM_W-1:0];
                default:    dims_next = dims_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg.rows_a <= DIM_RESET;
            dims_reg.cols_a <= DIM_RESET;
            dims_reg.rows_b <= DIM_RESET;
            dims_reg.cols_b <= DIM_RESET;
        end
        else
        begin
            dims_reg <= dims_next;
        end
    end

    // Read back the addressed register, zero-extended.
    always_comb
    begin
        unique case (paddr[3:2])
            REG_ROWS_A: rd_dim = dims_reg.rows_a;
            REG_COLS_A: rd_dim = dims_reg.cols_a;
            REG_ROWS_B: rd_dim = dims_reg.rows_b;
            REG_COLS_B: rd_dim = dims_reg.cols_b;
            default:    rd_dim = '0;
        endcase
    end

    assign prdata = {{(32 - DIM_W){1'b0}}, rd_dim};

    // Controller: accept loads while idle, sequence the merge and error report.
    smcoo_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req_item.cmd),
        .req_stall (req_stall),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    // Datapath: stores, pointers, compare and add, and the result register
    // that decouples the result side from the request side.
    smcoo_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_item  (req_item),
        .dims      (dims_reg),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item)
    );

endmodule

// File: rtl/core/smcoo_ctrl.sv
// Controller state machine for the coordinate-list matrix adder.
module smcoo_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic [1:0]            req_cmd,
    output logic                  req_stall,
    input  smcoo_pkg::dp_status_t status,
    output smcoo_pkg::dp_cmd_t    cmd
);
    import smcoo_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && (req_cmd == CMD_MERGE))
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                if (status.err != STATUS_ENTRY)
                begin
                    if (status.out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (status.out_free && status.merge_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_stall = 1'b1;
        cmd       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall       = 1'b0;
                cmd.load_first  = req_valid && (req_cmd == CMD_LOAD_FIRST);
                cmd.load_second = req_valid && (req_cmd == CMD_LOAD_SECOND);
            end
            ST_FETCH:
            begin
                if ((status.err != STATUS_ENTRY) && status.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    cmd.clear    = 1'b1;
                end
            end
            ST_MERGE:
            begin
                if (status.out_free)
                begin
                    cmd.emit_merge = 1'b1;
                    cmd.clear      = status.merge_last;
                end
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

// File: rtl/core/smcoo_dp.sv
// Datapath: list stores, counts, merge compare and add, result register.
module smcoo_dp #(
    parameter int DEPTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  smcoo_pkg::in_item_t   req_item,
    input  smcoo_pkg::dims_t      dims,
    input  smcoo_pkg::dp_cmd_t    cmd,
    output smcoo_pkg::dp_status_t status,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output smcoo_pkg::out_item_t  rsp_item
);
    import smcoo_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [ENTRY_W-1:0] mem_a [DEPTH];
    logic [ENTRY_W-1:0] mem_b [DEPTH];
    logic [ENTRY_W-1:0] rd_a_reg;
    logic [ENTRY_W-1:0] rd_b_reg;

    logic [CNT_W-1:0] cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0] cnt_b_reg, cnt_b_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] ptr_a_reg, ptr_a_next;
    logic [CNT_W-1:0] ptr_b_reg, ptr_b_next;

    logic             out_valid_reg, out_valid_next;
    out_item_t        out_item_reg, out_item_next;

    logic [ENTRY_W-1:0]   load_entry;
    logic                 full_a, full_b;
    logic                 a_left, b_left;
    logic [2*IDX16_W-1:0] key_a, key_b;
    logic                 adv_a, adv_b;
    logic [CNT_W-1:0]     ptr_a_adv, ptr_b_adv;
    logic [VAL_W-1:0]     sum;
    logic [ENTRY_W-1:0]   sel_entry;

    assign load_entry = {req_item.row, req_item.col, req_item.value};
    assign full_a     = (cnt_a_reg >= CNT_W'(DEPTH));
    assign full_b     = (cnt_b_reg >= CNT_W'(DEPTH));

    // list stores: write at the fill count, read at the next pointer
    always_ff @(posedge clk)
    begin
        if (cmd.load_first && !full_a)
        begin
            mem_a[cnt_a_reg[IDX_W-1:0]] <= load_entry;
        end
        if (cmd.load_second && !full_b)
        begin
            mem_b[cnt_b_reg[IDX_W-1:0]] <= load_entry;
        end
        rd_a_reg <= mem_a[ptr_a_next[IDX_W-1:0]];
        rd_b_reg <= mem_b[ptr_b_next[IDX_W-1:0]];
    end

    // merge step
    always_comb
    begin
        a_left    = (ptr_a_reg < cnt_a_reg);
        b_left    = (ptr_b_reg < cnt_b_reg);
        key_a     = rd_a_reg[ENTRY_W-1:VAL_W];
        key_b     = rd_b_reg[ENTRY_W-1:VAL_W];
        adv_a     = a_left && (!b_left || (key_a <= key_b));
        adv_b     = b_left && (!a_left || (key_b <= key_a));
        ptr_a_adv = ptr_a_reg + CNT_W'(adv_a);
        ptr_b_adv = ptr_b_reg + CNT_W'(adv_b);
        sum       = rd_a_reg[VAL_W-1:0] + rd_b_reg[VAL_W-1:0];
        if (adv_a && adv_b)
        begin
            sel_entry = {key_a, sum};
        end
        else if (adv_a)
        begin
            sel_entry = rd_a_reg;
        end
        else
        begin
            sel_entry = rd_b_reg;
        end
    end

    // counts, overflow flag and pointers
    always_comb
    begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        ovf_next   = ovf_reg;
        ptr_a_next = ptr_a_reg;
        ptr_b_next = ptr_b_reg;
        if (cmd.load_first)
        begin
            if (full_a)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cnt_a_next = cnt_a_reg + CNT_W'(1);
            end
        end
        if (cmd.load_second)
        begin
            if (full_b)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                cnt_b_next = cnt_b_reg + CNT_W'(1);
            end
        end
        if (cmd.emit_merge)
        begin
            ptr_a_next = ptr_a_adv;
            ptr_b_next = ptr_b_adv;
        end
        if (cmd.clear)
        begin
            cnt_a_next = '0;
            cnt_b_next = '0;
            ovf_next   = 1'b0;
            ptr_a_next = '0;
            ptr_b_next = '0;
        end
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && rsp_stall;
        out_item_next  = out_item_reg;
        if (cmd.emit_err)
        begin
            out_valid_next          = 1'b1;
            out_item_next           = '0;
            out_item_next.status    = status.err;
            out_item_next.last      = 1'b1;
        end
        else if (cmd.emit_merge)
        begin
            out_valid_next          = 1'b1;
            out_item_next.out_row   = sel_entry[ENTRY_W-1 -: IDX16_W];
            out_item_next.out_col   = sel_entry[VAL_W +: IDX16_W];
            out_item_next.out_value = sel_entry[VAL_W-1:0];
            out_item_next.status    = STATUS_ENTRY;
            out_item_next.last      = status.merge_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            ovf_reg       <= 1'b0;
            ptr_a_reg     <= '0;
            ptr_b_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            ovf_reg       <= ovf_next;
            ptr_a_reg     <= ptr_a_next;
            ptr_b_reg     <= ptr_b_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    // error priority: mismatch, then overflow, then both lists empty
    always_comb
    begin
        if ((dims.rows_a != dims.rows_b) || (dims.cols_a != dims.cols_b))
        begin
            status.err = STATUS_MISMATCH;
        end
        else if (ovf_reg)
        begin
            status.err = STATUS_OVERFLOW;
        end
        else if ((cnt_a_reg == '0) && (cnt_b_reg == '0))
        begin
            status.err = STATUS_EMPTY;
        end
        else
        begin
            status.err = STATUS_ENTRY;
        end
        status.merge_last = (ptr_a_adv == cnt_a_reg) && (ptr_b_adv == cnt_b_reg);
        status.out_free   = !out_valid_reg || !rsp_stall;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_item_reg;

endmodule

// File: bench/tb.sv
// Self-checking testbench for the coordinate-list sparse matrix adder.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import smcoo_pkg::*;

    localparam int LIST_DEPTH   = 32;
    localparam int RANDOM_ITEMS = 360;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 4;

    // Predicts the merged sum list of the two loaded lists and checks the
    // block's results against it, in order.
    class sum_scoreboard;
        dims_t              dims;
        logic [ENTRY_W-1:0] list_first [LIST_DEPTH];
        logic [ENTRY_W-1:0] list_second [LIST_DEPTH];
        int unsigned        n_first;
        int unsigned        n_second;
        bit                 spilled;
        out_item_t          sums_due [$];
        out_item_t          held;
        bit                 held_valid;
        int                 errors;
        int                 merges;
        int                 entries_checked;
        int                 mismatch_runs;
        int                 overflow_runs;
        int                 empty_runs;

        function new();
            dims.rows_a     = DIM_RESET;
            dims.cols_a     = DIM_RESET;
            dims.rows_b     = DIM_RESET;
            dims.cols_b     = DIM_RESET;
            n_first         = 0;
            n_second        = 0;
            spilled         = 1'b0;
            held            = '0;
            held_valid      = 1'b0;
            errors          = 0;
            merges          = 0;
            entries_checked = 0;
            mismatch_runs   = 0;
            overflow_runs   = 0;
            empty_runs      = 0;
        endfunction

        function void set_dim(logic [1:0] idx, logic [DIM_W-1:0] v);
            case (idx)
                REG_ROWS_A: dims.rows_a = v;
                REG_COLS_A: dims.cols_a = v;
                REG_ROWS_B: dims.rows_b = v;
                REG_COLS_B: dims.cols_b = v;
                default: ;
            endcase
        endfunction

        // Hold back the newest result so the final one of a run can be marked.
        function void emit(logic [15:0] r, logic [15:0] c, logic [31:0] v, logic [1:0] st);
            if (held_valid)
                sums_due.push_back(held);
            held.out_row   = r;
            held.out_col   = c;
            held.out_value = v;
            held.status    = st;
            held.last      = 1'b0;
            held_valid     = 1'b1;
        endfunction

        function void note_request(in_item_t req);
            logic [ENTRY_W-1:0] a;
            logic [ENTRY_W-1:0] b;
            logic [31:0]        s;
            int unsigned        i;
            int unsigned        j;
            i = 0;
            j = 0;
            case (req.cmd)
                CMD_LOAD_FIRST:
                    if (n_first >= LIST_DEPTH) spilled = 1'b1;
                    else begin
                        list_first[n_first] = {req.row, req.col, req.value};
                        n_first++;
                    end
                CMD_LOAD_SECOND:
                    if (n_second >= LIST_DEPTH) spilled = 1'b1;
                    else begin
                        list_second[n_second] = {req.row, req.col, req.value};
                        n_second++;
                    end
                CMD_MERGE: begin
                    if (dims.rows_a != dims.rows_b || dims.cols_a != dims.cols_b) begin
                        emit(16'd0, 16'd0, 32'd0, STATUS_MISMATCH);
                        mismatch_runs++;
                    end else if (spilled) begin
                        emit(16'd0, 16'd0, 32'd0, STATUS_OVERFLOW);
                        overflow_runs++;
                    end else if (n_first == 0 && n_second == 0) begin
                        emit(16'd0, 16'd0, 32'd0, STATUS_EMPTY);
                        empty_runs++;
                    end else begin
                        // key is row:col, compared as one unsigned number
                        while (i < n_first && j < n_second) begin
                            a = list_first[i];
                            b = list_second[j];
                            if (a[63:32] < b[63:32]) begin
                                emit(a[63:48], a[47:32], a[31:0], STATUS_ENTRY);
                                i++;
                            end else if (a[63:32] > b[63:32]) begin
                                emit(b[63:48], b[47:32], b[31:0], STATUS_ENTRY);
                                j++;
                            end else begin
                                s = a[31:0] + b[31:0];
                                emit(a[63:48], a[47:32], s, STATUS_ENTRY);
                                i++;
                                j++;
                            end
                        end
                        for (; i < n_first; i++)
                            emit(list_first[i][63:48], list_first[i][47:32],
                                 list_first[i][31:0], STATUS_ENTRY);
                        for (; j < n_second; j++)
                            emit(list_second[j][63:48], list_second[j][47:32],
                                 list_second[j][31:0], STATUS_ENTRY);
                    end
                    held.last = 1'b1;
                    sums_due.push_back(held);
                    held_valid = 1'b0;
                    n_first    = 0;
                    n_second   = 0;
                    spilled    = 1'b0;
                    merges++;
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (sums_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = sums_due.pop_front();
            compare_field("out_row", 32'(want.out_row), 32'(got.out_row));
            compare_field("out_col", 32'(want.out_col), 32'(got.out_col));
            compare_field("out_value", 32'(want.out_value), 32'(got.out_value));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("last", 32'(want.last), 32'(got.last));
            if (want.status == STATUS_ENTRY)
                entries_checked++;
        endfunction
    endclass

    typedef enum int {
        BATCH_SORTED,
        BATCH_UNSORTED,
        BATCH_SPILL,
        BATCH_EMPTY
    } batch_kind_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    in_item_t    req_item  = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    out_item_t   rsp_item;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [3:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    sum_scoreboard sb = new();

    bit          calm          = 1'b0;  // no gaps and no new stalls while set
    int          requests_sent = 0;
    int          stall_left    = 0;
    int          cycles        = 0;
    int unsigned stall_roll;

    sparse_matrix_coo_add #(.DEPTH(LIST_DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_item  (req_item),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_item  (rsp_item),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // Watchdog: abandon the run if the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side: check every accepted transaction using the values seen
    // just before the edge, then pick the stall for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
            sb.check_result(rsp_item);
        if (stall_left == 0 && !calm) begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 20)
                stall_left = $urandom_range(1, 3);
            else if (stall_roll < 23)
                stall_left = $urandom_range(8, 40);
        end
        if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
        end else begin
            rsp_stall <= 1'b0;
        end
    end

    // Idle gap before a request: mostly none or short, now and then long.
    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Loaded values: lean on the extremes of the two's complement range.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 25)
            return 17'd1;
        if (r < 50)
            return DIM_RESET;
        return 17'($urandom_range(1, 65536));
    endfunction

    function automatic in_item_t make_req(logic [1:0] cmd, logic [15:0] row,
                                          logic [15:0] col, logic [31:0] value);
        in_item_t req;
        req.cmd   = cmd;
        req.row   = row;
        req.col   = col;
        req.value = value;
        return req;
    endfunction

    // Present one request and hold it until the block takes the transaction.
    // Valid stays high when the next request follows at once.
    task automatic send_request(input in_item_t req);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= req;
        do @(posedge clk); while (req_stall !== 1'b0);
        sb.note_request(req);
        if (req.cmd != CMD_NONE)
            requests_sent++;
    endtask

    // Drop valid, wait for every predicted result, then let the block go idle.
    task automatic settle();
        req_valid <= 1'b0;
        while (sb.sums_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One APB write: setup cycle, then access until pready.
    task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        sb.set_dim(idx, value);
    endtask

    task automatic write_dims(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ca,
                              input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb);
        write_reg(REG_ROWS_A, ra);
        write_reg(REG_COLS_A, ca);
        write_reg(REG_ROWS_B, rb);
        write_reg(REG_COLS_B, cb);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // New dimensions, mostly matching; now and then one of the second
    // matrix's dimensions is pulled off by one to force a mismatch.
    task automatic reconfigure();
        logic [DIM_W-1:0] r;
        logic [DIM_W-1:0] c;
        logic [DIM_W-1:0] rb;
        logic [DIM_W-1:0] cb;
        r  = pick_dim();
        c  = pick_dim();
        rb = r;
        cb = c;
        if ($urandom_range(0, 99) < 20) begin
            if ($urandom_range(0, 1) == 1)
                rb = (r == 17'd1) ? 17'd2 : r - 17'd1;
            else
                cb = (c == 17'd1) ? 17'd2 : c - 17'd1;
        end
        settle();
        write_dims(r, c, rb, cb);
    endtask

    // Build two lists from one rising key stream (or random keys for an
    // unsorted batch), interleave the loads, then issue the merge.
    task automatic run_batch(input batch_kind_t kind);
        logic [ENTRY_W-1:0] list_a [$];
        logic [ENTRY_W-1:0] list_b [$];
        logic [32:0]        key;
        logic [31:0]        va;
        logic [31:0]        vb;
        int unsigned        n_keys;
        int unsigned        max_step;
        int unsigned        pick;
        int                 ia;
        int                 ib;
        bit                 a_take;
        bit                 b_take;
        bit                 spill_first;

        spill_first = $urandom_range(0, 1);
        if (kind == BATCH_EMPTY)
            n_keys = 0;
        else if (kind == BATCH_SPILL)
            n_keys = $urandom_range(34, 40);
        else if ($urandom_range(0, 99) < 70)
            n_keys = $urandom_range(1, 12);
        else
            n_keys = $urandom_range(13, 48);
        case ($urandom_range(0, 3))
            0: max_step = 2;
            1: max_step = 16;
            2: max_step = 32'd1 << 20;
            default: max_step = 32'd1 << 28;
        endcase
        if (kind == BATCH_SPILL)
            max_step = 16;
        key = 33'($urandom_range(0, 32'hFFFF_0000));
        if ($urandom_range(0, 1) == 1)
            key = 33'($urandom_range(0, 64));

        for (int k = 0; k < n_keys; k++) begin
            if (kind == BATCH_UNSORTED)
                key = ($urandom_range(0, 1) == 1) ? 33'($urandom)
                                                  : 33'($urandom_range(0, 40));
            if (key > 33'h0_FFFF_FFFF)
                break;
            pick = $urandom_range(0, 99);
            va   = pick_value();
            vb   = ($urandom_range(0, 99) < 25) ? -va : pick_value();
            if (kind == BATCH_SPILL) begin
                a_take = spill_first || pick < 20;
                b_take = !spill_first || pick < 20;
                if (spill_first)
                    list_a.push_back({key[31:0], va});
                else
                    list_b.push_back({key[31:0], vb});
                if (pick < 20 && spill_first && list_b.size() < LIST_DEPTH)
                    list_b.push_back({key[31:0], vb});
                if (pick < 20 && !spill_first && list_a.size() < LIST_DEPTH)
                    list_a.push_back({key[31:0], va});
            end else begin
                a_take = pick < 35 || pick >= 70;
                b_take = pick >= 35;
                if (a_take && list_a.size() < LIST_DEPTH)
                    list_a.push_back({key[31:0], va});
                if (b_take && list_b.size() < LIST_DEPTH)
                    list_b.push_back({key[31:0], vb});
            end
            key = key + 33'($urandom_range(1, max_step));
        end

        ia = 0;
        ib = 0;
        while (ia < list_a.size() || ib < list_b.size()) begin
            // sprinkle the odd no-op command between the loads
            if ($urandom_range(0, 99) < 6)
                send_request(make_req(CMD_NONE, 16'($urandom), 16'($urandom), $urandom));
            if (ib >= list_b.size() || (ia < list_a.size() && $urandom_range(0, 1) == 1)) begin
                send_request(make_req(CMD_LOAD_FIRST, list_a[ia][63:48], list_a[ia][47:32],
                                      list_a[ia][31:0]));
                ia++;
            end else begin
                send_request(make_req(CMD_LOAD_SECOND, list_b[ib][63:48], list_b[ib][47:32],
                                      list_b[ib][31:0]));
                ib++;
            end
        end
        send_request(make_req(CMD_MERGE, 16'($urandom), 16'($urandom), $urandom));
    endtask

    initial
    begin
        int          random_start;
        int unsigned kind_roll;
        batch_kind_t kind;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: merge with nothing loaded, at reset dimensions.
        send_request(make_req(CMD_MERGE, 16'd0, 16'd0, 32'd0));
        // A no-op command must leave the lists untouched.
        send_request(make_req(CMD_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send_request(make_req(CMD_MERGE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));

        // Matching keys: zero sum, wrap both ways, extremes of row and column.
        send_request(make_req(CMD_LOAD_FIRST, 16'd0, 16'd0, 32'd5));
        send_request(make_req(CMD_LOAD_SECOND, 16'd0, 16'd0, 32'hFFFF_FFFB));
        send_request(make_req(CMD_LOAD_SECOND, 16'd0, 16'd3, 32'd0));
        send_request(make_req(CMD_LOAD_FIRST, 16'd0, 16'd7, 32'h8000_0000));
        send_request(make_req(CMD_LOAD_FIRST, 16'd1, 16'd0, 32'hFFFF_FFFF));
        send_request(make_req(CMD_LOAD_SECOND, 16'd1, 16'd0, 32'h8000_0000));
        send_request(make_req(CMD_LOAD_FIRST, 16'hFFFF, 16'hFFFF, 32'h7FFF_FFFF));
        send_request(make_req(CMD_LOAD_SECOND, 16'hFFFF, 16'hFFFF, 32'd1));
        send_request(make_req(CMD_MERGE, 16'd0, 16'd0, 32'd0));

        // One list empty: the other is copied straight through.
        send_request(make_req(CMD_LOAD_FIRST, 16'd2, 16'd2, 32'd123));
        send_request(make_req(CMD_LOAD_FIRST, 16'd40000, 16'd1, 32'hFFFF_FFF9));
        send_request(make_req(CMD_MERGE, 16'd0, 16'd0, 32'd0));
        send_request(make_req(CMD_LOAD_SECOND, 16'd0, 16'hFFFF, 32'd9));
        send_request(make_req(CMD_MERGE, 16'd0, 16'd0, 32'd0));

        // Row count differs, then column count differs.
        settle();
        write_dims(DIM_RESET, DIM_RESET, 17'd1, DIM_RESET);
        send_request(make_req(CMD_LOAD_FIRST, 16'd7, 16'd7, 32'd77));
        send_request(make_req(CMD_MERGE, 16'd0, 16'd0, 32'd0));
        settle();
        write_dims(DIM_RESET, 17'd1, DIM_RESET, DIM_RESET);
        send_request(make_req(CMD_LOAD_SECOND, 16'd7, 16'd7, 32'd77));
        send_request(make_req(CMD_MERGE, 16'd0, 16'd0, 32'd0));

        // Smallest dimensions; coordinates beyond them are not checked.
        settle();
        write_dims(17'd1, 17'd1, 17'd1, 17'd1);
        send_request(make_req(CMD_LOAD_FIRST, 16'd5, 16'd5, 32'd10));
        send_request(make_req(CMD_LOAD_SECOND, 16'd5, 16'd5, 32'd20));
        send_request(make_req(CMD_MERGE, 16'd0, 16'd0, 32'd0));

        // Random: open with a store overflow, then mixed batches.
        random_start = requests_sent;
        run_batch(BATCH_SPILL);
        while (requests_sent - random_start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 35)
                reconfigure();
            calm      = ($urandom_range(0, 99) < 20);
            kind_roll = $urandom_range(0, 99);
            if (kind_roll < 72)
                kind = BATCH_SORTED;
            else if (kind_roll < 84)
                kind = BATCH_UNSORTED;
            else if (kind_roll < 93)
                kind = BATCH_SPILL;
            else
                kind = BATCH_EMPTY;
            run_batch(kind);
        end

        // Drain, then give stray results a chance to show up.
        calm = 1'b0;
        settle();
        repeat (16) @(posedge clk);

        $display("run covered %0d requests in %0d merges, %0d sum entries checked",
                 requests_sent, sb.merges, sb.entries_checked);
        $display("error results: %0d dimension mismatch, %0d overflow, %0d empty",
                 sb.mismatch_runs, sb.overflow_runs, sb.empty_runs);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
